FILE: hw/rtl/water_level_classifier_core_defines.svh
`ifndef WATER_LEVEL_CLASSIFIER_CORE_DEFINES_SVH
`define WATER_LEVEL_CLASSIFIER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define WLC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, disabled while reset is high.
`define WLC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

// Implication after a fixed number of cycles, disabled while reset is high.
`define WLC_ASSERT_DELAY(label, clk, rst, ante, dly, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error("delayed check failed");

`endif

FILE: hw/rtl/wlc_pkg.sv
package wlc_pkg;

   localparam int WLC_NUM_W = 32;
   localparam int WLC_SAMPLE_W = 12;
   localparam int WLC_MV_W = 13;
   localparam int WLC_SERIES_W = 20;
   localparam int WLC_CSR_IDX_W = 3;

   localparam logic [WLC_CSR_IDX_W-1:0] CSR_VREF_MV = 3'd0;
   localparam logic [WLC_CSR_IDX_W-1:0] CSR_SERIES_OHM = 3'd1;
   localparam logic [WLC_CSR_IDX_W-1:0] CSR_DRY_LIMIT_MV = 3'd2;
   localparam logic [WLC_CSR_IDX_W-1:0] CSR_WET_LIMIT_MV = 3'd3;
   localparam logic [WLC_CSR_IDX_W-1:0] CSR_SUBMERGED_LIMIT_MV = 3'd4;

   localparam logic [WLC_MV_W-1:0] VREF_MV_RESET = 13'd3300;
   localparam logic [WLC_SERIES_W-1:0] SERIES_OHM_RESET = 20'd100000;
   localparam logic [WLC_MV_W-1:0] DRY_LIMIT_RESET = 13'd500;
   localparam logic [WLC_MV_W-1:0] WET_LIMIT_RESET = 13'd1500;
   localparam logic [WLC_MV_W-1:0] SUBMERGED_LIMIT_RESET = 13'd2500;

   localparam logic [1:0] LEVEL_DRY = 2'd0;
   localparam logic [1:0] LEVEL_WET = 2'd1;
   localparam logic [1:0] LEVEL_SUBMERGED = 2'd2;
   localparam logic [1:0] LEVEL_OVER = 2'd3;

   typedef struct packed {
      logic valid;
      logic full_scale;
   } wlc_tag_type;

endpackage

FILE: hw/rtl/wlc_div_cell.sv
module wlc_div_cell #(
   parameter int DEN_W = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  wlc_pkg::wlc_tag_type          tag_up,
   input  logic [DEN_W-1:0]              ohm_den_up,
   input  logic [DEN_W-1:0]              ohm_rem_up,
   input  logic [wlc_pkg::WLC_NUM_W-1:0] ohm_num_up,
   input  logic [wlc_pkg::WLC_MV_W-1:0]  mv_up,
   output wlc_pkg::wlc_tag_type          tag_dn,
   output logic [DEN_W-1:0]              ohm_den_dn,
   output logic [DEN_W-1:0]              ohm_rem_dn,
   output logic [wlc_pkg::WLC_NUM_W-1:0] ohm_num_dn,
   output logic [wlc_pkg::WLC_MV_W-1:0]  mv_dn
);
   import wlc_pkg::*;

   wlc_tag_type            tag_ff;
   logic [DEN_W-1:0]       ohm_den_ff;
   logic [DEN_W-1:0]       ohm_rem_ff, ohm_rem_in;
   logic [WLC_NUM_W-1:0]   ohm_num_ff, ohm_num_in;
   logic [WLC_MV_W-1:0]    mv_ff;

   logic [DEN_W:0]         ohm_shift;
   logic [DEN_W+1:0]       ohm_diff;
   logic                   ohm_qbit;

   // One restoring step: the next dividend bit enters the partial remainder,
   // and the quotient bit shifts into the freed dividend LSB.
   always_comb begin
      ohm_shift = {ohm_rem_up, ohm_num_up[WLC_NUM_W-1]};
      ohm_diff = {1'b0, ohm_shift} - {2'b00, ohm_den_up};
      ohm_qbit = ~ohm_diff[DEN_W+1];
      ohm_rem_in = ohm_qbit ? ohm_diff[DEN_W-1:0] : ohm_shift[DEN_W-1:0];
      ohm_num_in = {ohm_num_up[WLC_NUM_W-2:0], ohm_qbit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= tag_up;
      end
   end

   // The voltage is already final here and only travels with its transaction.
   always_ff @(posedge clock) begin
      ohm_den_ff <= ohm_den_up;
      ohm_rem_ff <= ohm_rem_in;
      ohm_num_ff <= ohm_num_in;
      mv_ff <= mv_up;
   end

   assign tag_dn = tag_ff;
   assign ohm_den_dn = ohm_den_ff;
   assign ohm_rem_dn = ohm_rem_ff;
   assign ohm_num_dn = ohm_num_ff;
   assign mv_dn = mv_ff;

endmodule

FILE: hw/rtl/wlc_classifier.sv
module wlc_classifier (
   input  logic                           clock,
   input  logic                           reset,
   input  wlc_pkg::wlc_tag_type           tag_in,
   input  logic [wlc_pkg::WLC_MV_W-1:0]   mv_quot,
   input  logic [wlc_pkg::WLC_NUM_W-1:0]  ohm_quot,
   input  logic [wlc_pkg::WLC_MV_W-1:0]   dry_limit_mv,
   input  logic [wlc_pkg::WLC_MV_W-1:0]   wet_limit_mv,
   input  logic [wlc_pkg::WLC_MV_W-1:0]   submerged_limit_mv,
   output logic                           rsp_strobe,
   output logic [wlc_pkg::WLC_MV_W-1:0]   rsp_voltage_mv,
   output logic [31:0]                    rsp_resistance_ohm,
   output logic [1:0]                     rsp_immersion_level,
   output logic                           rsp_measure_error
);
   import wlc_pkg::*;

   logic                 strobe_ff;
   logic [WLC_MV_W-1:0]  voltage_ff, voltage_in;
   logic [31:0]          ohm_ff, ohm_in;
   logic [1:0]           level_ff, level_in;
   logic                 error_ff, error_in;
   logic [WLC_MV_W-1:0]  mv;

   always_comb begin
      mv = mv_quot;
      if (tag_in.full_scale) begin
         voltage_in = '0;
         ohm_in = '0;
         level_in = LEVEL_OVER;
      end else begin
         voltage_in = mv;
         ohm_in = ohm_quot[31:0];
         // Thresholds are tested in fixed order; they need not be rising.
         if (mv < dry_limit_mv) begin
            level_in = LEVEL_DRY;
         end else if (mv < wet_limit_mv) begin
            level_in = LEVEL_WET;
         end else if (mv < submerged_limit_mv) begin
            level_in = LEVEL_SUBMERGED;
         end else begin
            level_in = LEVEL_OVER;
         end
      end
      error_in = (level_in == LEVEL_OVER);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= tag_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      voltage_ff <= voltage_in;
      ohm_ff <= ohm_in;
      level_ff <= level_in;
      error_ff <= error_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_voltage_mv = voltage_ff;
   assign rsp_resistance_ohm = ohm_ff;
   assign rsp_immersion_level = level_ff;
   assign rsp_measure_error = error_ff;

endmodule

FILE: hw/rtl/water_level_classifier_core.sv
// A start reaches rsp_strobe via the entry stage, divider cells and classifier.
// Throughput: one transaction per cycle while not busy; busy drops after reset ends.
// A chain of 32 divider cells, one quotient bit each, sets the latency.
// Reset (synchronous, active high) restores the register defaults, drops every
// transaction in flight and holds busy high during reset and the cycle after.
module water_level_classifier_core #(
   parameter int ADC_FULL_SCALE = 4095
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [wlc_pkg::WLC_SAMPLE_W-1:0]    req_adc_sample,
   output logic                                rsp_strobe,
   output logic [wlc_pkg::WLC_MV_W-1:0]        rsp_voltage_mv,
   output logic [31:0]                         rsp_resistance_ohm,
   output logic [1:0]                          rsp_immersion_level,
   output logic                                rsp_measure_error,
   input  logic                                csr_write_en,
   input  logic [wlc_pkg::WLC_CSR_IDX_W-1:0]   csr_index,
   input  logic [wlc_pkg::WLC_SERIES_W-1:0]    csr_write_data
);
   import wlc_pkg::*;

   `include "water_level_classifier_core_defines.svh"

   localparam int DEN_W = $clog2(ADC_FULL_SCALE + 1);
   localparam int CMP_W = (DEN_W > WLC_SAMPLE_W) ? DEN_W : WLC_SAMPLE_W;
   localparam logic [CMP_W-1:0] FS_CMP = CMP_W'(ADC_FULL_SCALE);
   localparam int LATENCY = WLC_NUM_W + 2;
   localparam int MV_PROD_W = WLC_MV_W + WLC_SAMPLE_W;
   localparam int RECIP_SHIFT = MV_PROD_W + DEN_W;
   localparam int RECIP_W = MV_PROD_W + 2;
   localparam int SCALED_W = RECIP_SHIFT + WLC_MV_W;
   localparam logic [63:0] FS_WIDE = 64'(ADC_FULL_SCALE);
   localparam logic [RECIP_W-1:0] MV_RECIP =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + FS_WIDE - 64'd1) / FS_WIDE);

   logic                   busy_ff;
   logic [WLC_MV_W-1:0]    vref_ff, dry_ff, wet_ff, sub_ff;
   logic [WLC_SERIES_W-1:0] series_ff;

   wlc_tag_type            s0_tag_ff, s0_tag_in;
   logic [WLC_NUM_W-1:0]   s0_ohm_num_ff, s0_ohm_num_in;
   logic [MV_PROD_W-1:0]   s0_mv_num_ff, s0_mv_num_in;
   logic [DEN_W-1:0]       s0_den_ff, s0_den_in;
   logic [CMP_W-1:0]       sample_cmp;
   logic [SCALED_W-1:0]    mv_scaled;
   logic                   accept;
   logic                   accept_full_scale;
   logic                   rsp_zero;
   logic                   rsp_level_over;

   wlc_tag_type            tag_chain [0:WLC_NUM_W];
   logic [DEN_W-1:0]       den_chain [0:WLC_NUM_W];
   logic [DEN_W-1:0]       ohm_rem_chain [0:WLC_NUM_W];
   logic [WLC_NUM_W-1:0]   ohm_num_chain [0:WLC_NUM_W];
   logic [WLC_MV_W-1:0]    mv_chain [0:WLC_NUM_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy = busy_ff;
   assign accept = start && !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vref_ff <= VREF_MV_RESET;
         series_ff <= SERIES_OHM_RESET;
         dry_ff <= DRY_LIMIT_RESET;
         wet_ff <= WET_LIMIT_RESET;
         sub_ff <= SUBMERGED_LIMIT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_VREF_MV: vref_ff <= csr_write_data[WLC_MV_W-1:0];
            CSR_SERIES_OHM: series_ff <= csr_write_data;
            CSR_DRY_LIMIT_MV: dry_ff <= csr_write_data[WLC_MV_W-1:0];
            CSR_WET_LIMIT_MV: wet_ff <= csr_write_data[WLC_MV_W-1:0];
            CSR_SUBMERGED_LIMIT_MV: sub_ff <= csr_write_data[WLC_MV_W-1:0];
            default: ;
         endcase
      end
   end

   // Entry stage: both dividends and the resistance divisor. The products
   // always fit in 32 bits, so the resistance quotient never saturates.
   always_comb begin
      sample_cmp = CMP_W'(req_adc_sample);
      s0_tag_in.valid = accept;
      s0_tag_in.full_scale = (sample_cmp >= FS_CMP);
      s0_ohm_num_in = WLC_NUM_W'(series_ff) * WLC_NUM_W'(req_adc_sample);
      s0_mv_num_in = MV_PROD_W'(vref_ff) * MV_PROD_W'(req_adc_sample);
      s0_den_in = DEN_W'(FS_CMP - sample_cmp);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_tag_ff <= '0;
      end else begin
         s0_tag_ff <= s0_tag_in;
      end
   end

   always_ff @(posedge clock) begin
      s0_ohm_num_ff <= s0_ohm_num_in;
      s0_mv_num_ff <= s0_mv_num_in;
      s0_den_ff <= s0_den_in;
   end

   // The voltage divides by the constant full scale through a rounded-up
   // reciprocal. Its error stays below one part in 2^DEN_W, so the floor is
   // exact for every product below full scale times the reference.
   assign mv_scaled = SCALED_W'(s0_mv_num_ff) * SCALED_W'(MV_RECIP);

   assign tag_chain[0] = s0_tag_ff;
   assign den_chain[0] = s0_den_ff;
   assign ohm_rem_chain[0] = '0;
   assign ohm_num_chain[0] = s0_ohm_num_ff;
   assign mv_chain[0] = mv_scaled[SCALED_W-1 -: WLC_MV_W];

   for (genvar i = 0; i < WLC_NUM_W; i++) begin : g_cell
      wlc_div_cell #(
         .DEN_W(DEN_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .tag_up    (tag_chain[i]),
         .ohm_den_up(den_chain[i]),
         .ohm_rem_up(ohm_rem_chain[i]),
         .ohm_num_up(ohm_num_chain[i]),
         .mv_up     (mv_chain[i]),
         .tag_dn    (tag_chain[i+1]),
         .ohm_den_dn(den_chain[i+1]),
         .ohm_rem_dn(ohm_rem_chain[i+1]),
         .ohm_num_dn(ohm_num_chain[i+1]),
         .mv_dn     (mv_chain[i+1])
      );
   end

   wlc_classifier u_classifier (
      .clock              (clock),
      .reset              (reset),
      .tag_in             (tag_chain[WLC_NUM_W]),
      .mv_quot            (mv_chain[WLC_NUM_W]),
      .ohm_quot           (ohm_num_chain[WLC_NUM_W]),
      .dry_limit_mv       (dry_ff),
      .wet_limit_mv       (wet_ff),
      .submerged_limit_mv (sub_ff),
      .rsp_strobe         (rsp_strobe),
      .rsp_voltage_mv     (rsp_voltage_mv),
      .rsp_resistance_ohm (rsp_resistance_ohm),
      .rsp_immersion_level(rsp_immersion_level),
      .rsp_measure_error  (rsp_measure_error)
   );

   assign accept_full_scale = accept && s0_tag_in.full_scale;
   assign rsp_zero = rsp_strobe && (rsp_voltage_mv == '0) && (rsp_resistance_ohm == '0);
   assign rsp_level_over = (rsp_immersion_level == LEVEL_OVER);

   `WLC_ASSERT_DELAY(a_latency, clock, reset, accept, LATENCY, rsp_strobe)
   `WLC_ASSERT_DELAY(a_full_scale_zero, clock, reset, accept_full_scale, LATENCY, rsp_zero)
   `WLC_ASSERT_NEXT(a_chain_to_out, clock, reset, tag_chain[WLC_NUM_W].valid, rsp_strobe)
   `WLC_ASSERT_IMP(a_error_level, clock, reset, rsp_strobe, rsp_measure_error == rsp_level_over)

endmodule
